/* design/u2u8_pkg.sv */
// ============================================================================
// u2u8_pkg
// Shared types, codes and constants of the Unicode to UTF-8 transcoder.
// ============================================================================
`default_nettype none

package u2u8_pkg;

    // Source encoding codes of the configuration register
    localparam logic [2:0] SRC_UTF8     = 3'd0;
    localparam logic [2:0] SRC_UTF8_BOM = 3'd1;
    localparam logic [2:0] SRC_UTF16LE  = 3'd2;
    localparam logic [2:0] SRC_UTF16BE  = 3'd3;
    localparam logic [2:0] SRC_UTF32LE  = 3'd4;
    localparam logic [2:0] SRC_UTF32BE  = 3'd5;

    // Register byte addresses
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_SOURCE_ENCODING = 3'd0;

    // UTF-8 range limits and byte marks
    localparam logic [31:0] LIMIT_1BYTE = 32'h0000_0080;
    localparam logic [31:0] LIMIT_2BYTE = 32'h0000_0800;
    localparam logic [31:0] LIMIT_3BYTE = 32'h0001_0000;
    localparam logic [31:0] MAX_CODE    = 32'h0010_FFFF;
    localparam logic [7:0]  LEAD_2BYTE  = 8'hC0;
    localparam logic [7:0]  LEAD_3BYTE  = 8'hE0;
    localparam logic [7:0]  LEAD_4BYTE  = 8'hF0;
    localparam logic [7:0]  CONT_MARK   = 8'h80;
    localparam logic [5:0]  CONT_MASK   = 6'h3F;

    localparam int unsigned BOM_LEN = 3;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_req_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       run_last;
        logic       stream_end;
        logic       out_of_range;
    } out_rsp_t;

    // One classified request: up to four formed UTF-8 bytes plus terminator flag
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            big;
        logic            last;
    } q_entry_t;

endpackage

`default_nettype wire

/* design/u2u8_front.sv */
// ============================================================================
// u2u8_front
// Accept source bytes, assemble code units and form their UTF-8 bytes.
// ============================================================================
`default_nettype none

module u2u8_front
    import u2u8_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic [2:0] enc,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_req_t  in_req,
    input  wire logic     queue_full,
    output logic          push,
    output q_entry_t      push_entry
);

    logic [23:0] unit_bytes_reg, unit_bytes_next;
    logic [1:0]  unit_count_reg, unit_count_next;
    logic [1:0]  bom_skip_reg, bom_skip_next;

    logic        accept;
    logic        do_code;
    logic        do_raw;
    logic [31:0] code;
    logic [7:0]  b;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_req.byte_in;

    // Update the unit collector and pick what the byte produces
    always_comb
    begin
        unit_bytes_next = unit_bytes_reg;
        unit_count_next = unit_count_reg;
        bom_skip_next   = bom_skip_reg;
        do_code         = 1'b0;
        do_raw          = 1'b0;
        code            = {24'd0, b};
        unique case (enc) inside
            SRC_UTF8:
            begin
                unit_bytes_next = '0;
                unit_count_next = '0;
                do_raw          = 1'b1;
            end
            SRC_UTF8_BOM:
            begin
                unit_bytes_next = '0;
                unit_count_next = '0;
                if (bom_skip_reg < 2'(BOM_LEN))
                begin
                    bom_skip_next = bom_skip_reg + 2'd1;
                end
                else
                begin
                    do_raw = 1'b1;
                end
            end
            SRC_UTF16LE, SRC_UTF16BE:
            begin
                if (unit_count_reg == 2'd0)
                begin
                    unit_bytes_next = {unit_bytes_reg[15:0], b};
                    unit_count_next = unit_count_reg + 2'd1;
                end
                else
                begin
                    unit_bytes_next = '0;
                    unit_count_next = '0;
                    do_code         = 1'b1;
                    if (enc == SRC_UTF16LE)
                    begin
                        code = {16'd0, b, unit_bytes_reg[7:0]};
                    end
                    else
                    begin
                        code = {16'd0, unit_bytes_reg[7:0], b};
                    end
                end
            end
            SRC_UTF32LE, SRC_UTF32BE:
            begin
                if (unit_count_reg != 2'd3)
                begin
                    unit_bytes_next = {unit_bytes_reg[15:0], b};
                    unit_count_next = unit_count_reg + 2'd1;
                end
                else
                begin
                    unit_bytes_next = '0;
                    unit_count_next = '0;
                    do_code         = 1'b1;
                    if (enc == SRC_UTF32LE)
                    begin
                        code = {b, unit_bytes_reg[7:0], unit_bytes_reg[15:8],
                                unit_bytes_reg[23:16]};
                    end
                    else
                    begin
                        code = {unit_bytes_reg, b};
                    end
                end
            end
            default:
            begin
                unit_bytes_next = '0;
                unit_count_next = '0;
                do_code         = 1'b1;
            end
        endcase
        if (in_req.last_byte)
        begin
            unit_bytes_next = '0;
            unit_count_next = '0;
            bom_skip_next   = '0;
        end
    end

    // Form the UTF-8 bytes of the entry
    always_comb
    begin
        push_entry.bytes  = '0;
        push_entry.nbytes = 3'd0;
        push_entry.big    = 1'b0;
        push_entry.last   = in_req.last_byte;
        if (do_raw)
        begin
            push_entry.bytes[0] = b;
            push_entry.nbytes   = 3'd1;
        end
        else if (do_code)
        begin
            if (code < LIMIT_1BYTE)
            begin
                push_entry.bytes[0] = code[7:0];
                push_entry.nbytes   = 3'd1;
            end
            else if (code < LIMIT_2BYTE)
            begin
                push_entry.bytes[0] = LEAD_2BYTE | {3'd0, code[10:6]};
                push_entry.bytes[1] = CONT_MARK | {2'd0, code[5:0] & CONT_MASK};
                push_entry.nbytes   = 3'd2;
            end
            else if (code < LIMIT_3BYTE)
            begin
                push_entry.bytes[0] = LEAD_3BYTE | {4'd0, code[15:12]};
                push_entry.bytes[1] = CONT_MARK | {2'd0, code[11:6] & CONT_MASK};
                push_entry.bytes[2] = CONT_MARK | {2'd0, code[5:0] & CONT_MASK};
                push_entry.nbytes   = 3'd3;
            end
            else
            begin
                // lead byte keeps only the low 8 bits of code >> 18
                push_entry.bytes[0] = LEAD_4BYTE | code[25:18];
                push_entry.bytes[1] = CONT_MARK | {2'd0, code[17:12] & CONT_MASK};
                push_entry.bytes[2] = CONT_MARK | {2'd0, code[11:6] & CONT_MASK};
                push_entry.bytes[3] = CONT_MARK | {2'd0, code[5:0] & CONT_MASK};
                push_entry.nbytes   = 3'd4;
                push_entry.big      = code > MAX_CODE;
            end
        end
    end

    assign push = accept && ((push_entry.nbytes != 3'd0) || in_req.last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_bytes_reg <= '0;
            unit_count_reg <= '0;
            bom_skip_reg   <= '0;
        end
        else if (accept)
        begin
            unit_bytes_reg <= unit_bytes_next;
            unit_count_reg <= unit_count_next;
            bom_skip_reg   <= bom_skip_next;
        end
    end

endmodule

`default_nettype wire

/* design/u2u8_queue.sv */
// ============================================================================
// u2u8_queue
// Short first-in first-out queue of classified entries.
// ============================================================================
`default_nettype none

module u2u8_queue
    import u2u8_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      head,
    output logic          full,
    output logic          empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    q_entry_t            entries_reg [Depth];
    logic [PtrW-1:0]     wptr_reg, wptr_next;
    logic [PtrW-1:0]     rptr_reg, rptr_next;
    logic [CntW-1:0]     count_reg, count_next;

    assign full  = (count_reg == CntW'(Depth));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PtrW'(Depth - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PtrW'(Depth - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/u2u8_back.sv */
// ============================================================================
// u2u8_back
// Step through the head entry; emit one UTF-8 byte per cycle unless stalled.
// ============================================================================
`default_nettype none

module u2u8_back
    import u2u8_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_entry_t head,
    input  wire logic     empty,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_rsp_t      out_rsp
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_rsp_t   out_rsp_reg, out_rsp_next;
    logic       load;
    logic [2:0] total;
    logic       at_end;

    assign load   = !out_valid_reg || out_ready;
    assign total  = head.nbytes + {2'd0, head.last};
    assign at_end = (idx_reg == total - 3'd1);
    assign pop    = load && !empty && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                idx_next = at_end ? 3'd0 : idx_reg + 3'd1;
                out_rsp_next.run_last = at_end;
                if (idx_reg < head.nbytes)
                begin
                    out_rsp_next.utf8_byte    = head.bytes[idx_reg[1:0]];
                    out_rsp_next.stream_end   = 1'b0;
                    out_rsp_next.out_of_range = head.big;
                end
                else
                begin
                    // terminator after the final input
                    out_rsp_next.utf8_byte    = 8'd0;
                    out_rsp_next.stream_end   = 1'b1;
                    out_rsp_next.out_of_range = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_rsp_reg <= out_rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

endmodule

`default_nettype wire

/* design/unicode_to_utf8_converter_top.sv */
// ============================================================================
// unicode_to_utf8_converter_top
// Byte-stream transcoder from UTF-8/UTF-16/UTF-32/Latin-1 to UTF-8.
// ============================================================================
// Usage:
//   Program source_encoding through the APB port (byte address 0) while idle.
//   Feed source bytes on in_valid/in_ready/in_req, one request per byte, with
//   last_byte set on the final byte of a text. Take UTF-8 bytes from
//   out_valid/out_ready/out_rsp; run_last marks the last byte a request caused
//   and stream_end marks the 0x00 terminator that follows the final byte.
// Timing:
//   The front accepts a request every cycle while the queue has room and
//   writes its formed bytes into the queue at the accepting edge. The back
//   presents them from its output register, one byte per cycle while
//   out_ready is high. A request yields 1 to 5 output bytes (none when it
//   only collects or drops a byte). The single output port sets the
//   sustained rate, as upper-half Latin-1 characters yield two bytes each.
// Reset:
//   Clears the encoding to UTF-8, the unit collector, the BOM counter, the
//   queue pointers and the output valid flag. No clearing pass is needed.
// Stalls:
//   When out_ready is low the output byte holds; the queue keeps taking
//   requests until it fills, then in_ready drops.
// ============================================================================
`default_nettype none

module unicode_to_utf8_converter_top
    import u2u8_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // source byte requests
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_req_t               in_req,
    // UTF-8 byte results
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_rsp_t                   out_rsp
);

    logic [2:0] enc_reg, enc_next;
    logic       reg_sel;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    q_entry_t   push_entry;
    q_entry_t   head;

    // Decode the word address; the low address bits are ignored
    assign reg_sel = ({paddr[APB_ADDR_W-1:2], 2'b00} == ADDR_SOURCE_ENCODING);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {29'd0, enc_reg} : 32'd0;

    // Write the encoding on the access phase of a write
    always_comb
    begin
        enc_next = enc_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            enc_next = pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg <= SRC_UTF8;
        end
        else
        begin
            enc_reg <= enc_next;
        end
    end

    // Accept and classify source bytes
    u2u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc        (enc_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_req     (in_req),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple front and back
    u2u8_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    // Emit formed bytes and terminators
    u2u8_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

endmodule

`default_nettype wire
